>>> rtl/tti_pkg.sv
package tti_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned NumChan    = 9;
  localparam int unsigned ValW       = NumChan * 32;

  localparam logic [1:0] ReqAppend = 2'd0;
  localparam logic [1:0] ReqQuery  = 2'd1;
  localparam logic [1:0] ReqClear  = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StEmpty   = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StOrder   = 2'd3;

  typedef enum logic [1:0] {
    OpNone,
    OpAppend,
    OpQuery
  } op_e;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    op_e              op;
    logic [1:0]       status;
    logic [IdxW-1:0]  widx;
    logic [IdxW-1:0]  last;
    logic [31:0]      tm;
    logic [ValW-1:0]  vals;
  } cmd_t;

endpackage

>>> rtl/tti_front.sv
module tti_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    req_type_i,
  input  logic [31:0]   time_us_i,
  input  logic [tti_pkg::ValW-1:0] vals_i,
  output logic          q_valid_o,
  input  logic          q_stall_i,
  output tti_pkg::cmd_t q_cmd_o
);
  import tti_pkg::*;

  // Two-entry queue towards the back end.
  cmd_t            fifo_q [2];
  logic            wp_q, rp_q, wp_d, rp_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     last_t_q, last_t_d;
  logic            push, pop;
  cmd_t            cmd;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && !q_stall_i;
  assign q_cmd_o    = fifo_q[rp_q];

  always_comb begin
    cmd        = '0;
    cmd.op     = OpNone;
    cmd.status = StOk;
    cmd.widx   = count_q[IdxW-1:0];
    cmd.last   = count_q[IdxW-1:0] - 1'b1;
    cmd.tm     = time_us_i;
    cmd.vals   = vals_i;
    count_d    = count_q;
    last_t_d   = last_t_q;
    case (req_type_i)
      ReqAppend: begin
        if (count_q == CntW'(TableDepth)) begin
          cmd.status = StFull;
        end else if (count_q != '0 && time_us_i < last_t_q) begin
          cmd.status = StOrder;
        end else begin
          cmd.op   = OpAppend;
          count_d  = count_q + 1'b1;
          last_t_d = time_us_i;
        end
      end
      ReqQuery: begin
        if (count_q == '0) begin
          cmd.status = StEmpty;
        end else begin
          cmd.op = OpQuery;
        end
      end
      ReqClear: count_d = '0;
      default: ;
    endcase
  end

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = ~wp_q;
    end
    if (pop) begin
      rp_d = ~rp_q;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= 1'b0;
      rp_q     <= 1'b0;
      cnt_q    <= '0;
      count_q  <= '0;
      last_t_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
      if (push) begin
        count_q  <= count_d;
        last_t_q <= last_t_d;
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth)) else $error("point count overflow");
`endif
endmodule

>>> rtl/tti_div.sv
module tti_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [16:0] quo_o
);
  import tti_pkg::*;

  // Restoring division of (num << 16) by den, one quotient bit per cycle.
  // num < den holds, so the quotient fits in 16 bits.
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q;
  logic [15:0] quo_q;
  logic [4:0]  n_q;
  logic        busy_q;
  logic [33:0] sh;

  assign sh     = {rem_q, 1'b0};
  assign rem_d  = (sh >= {2'b0, den_q}) ? 33'(sh - {2'b0, den_q}) : sh[32:0];
  assign done_o = busy_q && (n_q == 5'd0);
  assign quo_o  = {1'b0, quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      n_q    <= 5'd16;
    end else if (busy_q) begin
      if (n_q == 5'd0) begin
        busy_q <= 1'b0;
      end else begin
        n_q <= n_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q && n_q != 5'd0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[14:0], (sh >= {2'b0, den_q})};
    end
  end

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && n_q != 5'd0 |-> !start_i) else $error("divider restarted");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && n_q == 5'd16) else $error("divider did not start");
`endif
endmodule

>>> rtl/tti_back.sv
module tti_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_stall_o,
  input  tti_pkg::cmd_t q_cmd_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    status_o,
  output logic [tti_pkg::ValW-1:0] vals_o
);
  import tti_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDEND = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SCMP  = 4'd4;
  localparam logic [3:0] S_BRK   = 4'd5;
  localparam logic [3:0] S_BRK2  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_SUM   = 4'd9;
  localparam logic [3:0] S_COPY  = 4'd10;
  localparam logic [3:0] S_COPY2 = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [31:0]     tmem [TableDepth];
  logic [ValW-1:0] vmem [TableDepth];

  logic [3:0]      st_q;
  logic [31:0]     t_q, t_rd_q, t1_q, t2_q;
  logic [ValW-1:0] v_rd_q, p1_q;
  logic [IdxW-1:0] last_q, lo_q, hi_q, raddr;
  logic [IdxW-1:0] mid;
  logic            rd_en;
  logic [1:0]      stat_q;
  logic [ValW-1:0] res_q;
  logic [3:0]      ch_q;
  logic [49:0]     prod_q;
  logic [16:0]     alpha;
  logic            div_start, div_done;
  logic [31:0]     dt;
  logic            head_chk_q;

  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign q_stall_o = (st_q != S_IDLE);
  assign out_valid_o = (st_q == S_OUT);
  assign status_o  = stat_q;
  assign vals_o    = res_q;
  assign dt        = t2_q - t1_q;
  assign div_start = (st_q == S_BRK2) && !head_chk_q && (dt > 32'd1) && (t_q != t2_q);

  tti_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (t_q - t1_q),
    .den_i  (dt),
    .done_o (div_done),
    .quo_o  (alpha)
  );

  always_comb begin
    rd_en = 1'b1;
    raddr = '0;
    case (st_q)
      S_IDLE:  raddr = '0;
      S_RDEND: raddr = last_q;
      S_SRD:   raddr = mid;
      S_BRK:   raddr = lo_q - 1'b1;
      S_COPY:  raddr = lo_q;
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i && q_cmd_i.op == OpAppend) begin
      tmem[q_cmd_i.widx] <= q_cmd_i.tm;
      vmem[q_cmd_i.widx] <= q_cmd_i.vals;
    end
    if (rd_en) begin
      t_rd_q <= tmem[raddr];
      v_rd_q <= vmem[raddr];
    end
  end

  // Channel lane of the shared multiplier.
  logic signed [31:0] a_ch, b_ch;
  logic signed [32:0] diff;
  logic signed [49:0] sum;
  assign a_ch = p1_q[ch_q*32 +: 32];
  assign b_ch = v_rd_q[ch_q*32 +: 32];
  assign diff = 33'(b_ch) - 33'(a_ch);
  assign sum  = 50'(a_ch) + (signed'(prod_q) >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      head_chk_q <= 1'b0;
      stat_q <= StOk;
      ch_q <= '0;
    end else begin
      case (st_q)
        S_IDLE: if (q_valid_i) begin
          t_q    <= q_cmd_i.tm;
          last_q <= q_cmd_i.last;
          stat_q <= q_cmd_i.status;
          res_q  <= '0;
          if (q_cmd_i.op == OpQuery) begin
            st_q <= S_RDEND;
          end else begin
            st_q <= S_OUT;
          end
        end
        S_RDEND: begin
          // Entry 0 is now in the read register.
          if (t_q <= t_rd_q) begin
            res_q <= v_rd_q;
            st_q  <= S_OUT;
          end else begin
            st_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (t_q >= t_rd_q) begin
            res_q <= v_rd_q;
            st_q  <= S_OUT;
          end else begin
            lo_q <= IdxW'(1);
            hi_q <= last_q;
            st_q <= (last_q == IdxW'(1)) ? S_BRK : S_SRD;
          end
        end
        S_SRD: st_q <= S_SCMP;
        S_SCMP: begin
          if (t_rd_q < t_q) begin
            lo_q <= mid + 1'b1;
            st_q <= (mid + 1'b1 == hi_q) ? S_BRK : S_SRD;
          end else begin
            hi_q <= mid;
            st_q <= (lo_q == mid) ? S_BRK : S_SRD;
          end
        end
        S_BRK: begin
          // Lower point is read at lo - 1 here; the upper one, at lo, is read after it.
          head_chk_q <= 1'b1;
          st_q <= S_BRK2;
        end
        S_BRK2: begin
          if (head_chk_q) begin
            t1_q <= t_rd_q;
            p1_q <= v_rd_q;
            head_chk_q <= 1'b0;
            st_q <= S_COPY;
          end else if (dt <= 32'd1) begin
            res_q <= p1_q;
            st_q  <= S_OUT;
          end else if (t_q == t2_q) begin
            res_q <= v_rd_q;
            st_q  <= S_OUT;
          end else begin
            ch_q <= '0;
            st_q <= S_DIV;
          end
        end
        S_COPY: st_q <= S_COPY2;
        S_COPY2: begin
          t2_q <= t_rd_q;
          st_q <= S_BRK2;
        end
        S_DIV: if (div_done) begin
          st_q <= S_MUL;
        end
        S_MUL: begin
          prod_q <= 50'($signed({1'b0, alpha}) * diff);
          st_q   <= S_SUM;
        end
        S_SUM: begin
          res_q[ch_q*32 +: 32] <= sum[31:0];
          if (ch_q == 4'(NumChan - 1)) begin
            st_q <= S_OUT;
          end else begin
            ch_q <= ch_q + 1'b1;
            st_q <= S_MUL;
          end
        end
        S_OUT: if (!out_stall_i) begin
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_q))
    else $error("result changed while stalled");
  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_SCMP |-> lo_q <= hi_q) else $error("search bounds crossed");
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> st_q == S_DIV) else $error("divide outside its state");
`endif
endmodule

>>> rtl/trajectory_table_interpolator_top.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | req_type_i, time_us_i, nine channels
// out     | output    | out_valid_o/out_stall_i | status_o, nine out_ channels
// Append, clear and rejected items go through the front queue to a result beat; a clamped
// query reads only the end entries, and an interpolated one runs a binary search over the
// time memory (ten steps at most), a restoring divide, and a multiply and a sum per channel
// on the shared multiplier. Reset is asynchronous and empties the table at once.
// A stalled result holds the back end; the front queue keeps taking two items.
module trajectory_table_interpolator_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        time_us_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] acc_x_i,
  input  logic signed [31:0] acc_y_i,
  input  logic signed [31:0] acc_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] out_pos_x_o,
  output logic signed [31:0] out_pos_y_o,
  output logic signed [31:0] out_pos_z_o,
  output logic signed [31:0] out_vel_x_o,
  output logic signed [31:0] out_vel_y_o,
  output logic signed [31:0] out_vel_z_o,
  output logic signed [31:0] out_acc_x_o,
  output logic signed [31:0] out_acc_y_o,
  output logic signed [31:0] out_acc_z_o
);
  import tti_pkg::*;

  logic            q_valid, q_stall;
  cmd_t            q_cmd;
  logic [ValW-1:0] res;

  tti_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .req_type_i(req_type_i),
    .time_us_i (time_us_i),
    .vals_i    ({acc_z_i, acc_y_i, acc_x_i, vel_z_i, vel_y_i, vel_x_i,
                 pos_z_i, pos_y_i, pos_x_i}),
    .q_valid_o (q_valid),
    .q_stall_i (q_stall),
    .q_cmd_o   (q_cmd)
  );

  tti_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_stall_o  (q_stall),
    .q_cmd_i    (q_cmd),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .vals_o     (res)
  );

  assign out_pos_x_o = res[31:0];
  assign out_pos_y_o = res[63:32];
  assign out_pos_z_o = res[95:64];
  assign out_vel_x_o = res[127:96];
  assign out_vel_y_o = res[159:128];
  assign out_vel_z_o = res[191:160];
  assign out_acc_x_o = res[223:192];
  assign out_acc_y_o = res[255:224];
  assign out_acc_z_o = res[287:256];
endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tti_pkg::*;

  typedef logic [8:0][31:0] chans_t;

  typedef struct packed {
    logic [1:0] st;
    chans_t     ch;
  } sample_t;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] tm;
    chans_t      ch;
    bit          typed;
    logic [1:0]  st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = ReqQuery;
  logic [31:0] time_us = '0;
  chans_t drv_ch = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  chans_t mon_ch;

  // Own copy of the table for prediction.
  logic [31:0] pt_time [TableDepth];
  chans_t      pt_val  [TableDepth];
  int unsigned pt_cnt;

  sample_t expected_q [$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned in_idle = 30;
  int unsigned out_idle = 77;
  int unsigned quiet = 0;
  bit timed_out = 1'b0;

  always #5 clk = ~clk;

  trajectory_table_interpolator_top u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .req_type_i(req_type), .time_us_i(time_us),
    .pos_x_i(drv_ch[0]), .pos_y_i(drv_ch[1]), .pos_z_i(drv_ch[2]),
    .vel_x_i(drv_ch[3]), .vel_y_i(drv_ch[4]), .vel_z_i(drv_ch[5]),
    .acc_x_i(drv_ch[6]), .acc_y_i(drv_ch[7]), .acc_z_i(drv_ch[8]),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .status_o(status),
    .out_pos_x_o(mon_ch[0]), .out_pos_y_o(mon_ch[1]), .out_pos_z_o(mon_ch[2]),
    .out_vel_x_o(mon_ch[3]), .out_vel_y_o(mon_ch[4]), .out_vel_z_o(mon_ch[5]),
    .out_acc_x_o(mon_ch[6]), .out_acc_y_o(mon_ch[7]), .out_acc_z_o(mon_ch[8])
  );

  function automatic chans_t lerp_point(logic [31:0] t);
    int unsigned lo, hi, mid;
    logic [31:0] dt;
    longint unsigned alpha;
    longint signed a, b, prod;
    chans_t r;
    if (t <= pt_time[0]) return pt_val[0];
    if (t >= pt_time[pt_cnt-1]) return pt_val[pt_cnt-1];
    lo = 1;
    hi = pt_cnt - 1;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (pt_time[mid] < t) lo = mid + 1;
      else hi = mid;
    end
    dt = pt_time[lo] - pt_time[lo-1];
    if (dt <= 1) return pt_val[lo-1];
    if (t == pt_time[lo]) return pt_val[lo];
    alpha = ({32'd0, t - pt_time[lo-1]} << 16) / {32'd0, dt};
    for (int c = 0; c < 9; c++) begin
      a = longint'(signed'(pt_val[lo-1][c]));
      b = longint'(signed'(pt_val[lo][c]));
      prod = longint'(alpha) * (b - a);
      r[c] = 32'(a + (prod >>> 16));
    end
    return r;
  endfunction

  // Applies one accepted beat to the table copy and returns its result.
  function automatic sample_t apply_request(logic [1:0] req, logic [31:0] t, chans_t ch);
    sample_t s;
    s = '0;
    case (req)
      ReqAppend: begin
        if (pt_cnt >= TableDepth) s.st = StFull;
        else if (pt_cnt > 0 && t < pt_time[pt_cnt-1]) s.st = StOrder;
        else begin
          pt_time[pt_cnt] = t;
          pt_val[pt_cnt] = ch;
          pt_cnt++;
        end
      end
      ReqQuery: begin
        if (pt_cnt == 0) s.st = StEmpty;
        else s.ch = lerp_point(t);
      end
      ReqClear: pt_cnt = 0;
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_item(logic [1:0] req, logic [31:0] t, chans_t ch,
                           bit typed = 1'b0, logic [1:0] st = StOk);
    bit acc;
    sample_t s;
    in_idle = (sent < 370) ? 30 : (sent < 740) ? 77 : 0;
    out_idle = (sent < 370) ? 77 : (sent < 740) ? 30 : 0;
    while ($urandom_range(0, 99) < in_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    time_us <= t;
    drv_ch <= ch;
    do begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end while (!acc);
    s = apply_request(req, t, ch);
    if (typed) begin
      s = '0;
      s.st = st;
    end
    expected_q.insert(expected_q.size(), s);
    sent++;
  endtask

  function automatic logic [31:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic chans_t rand_point();
    chans_t ch;
    for (int c = 0; c < 9; c++) ch[c] = rand_chan();
    return ch;
  endfunction

  function automatic logic [31:0] span_time();
    int unsigned i;
    if (pt_cnt < 2 || $urandom_range(0, 9) == 0) return $urandom;
    i = $urandom_range(0, pt_cnt - 2);
    return pt_time[i] + $urandom_range(0, pt_time[i+1] - pt_time[i]);
  endfunction

  // A clear, a run of non-decreasing appends, then mostly in-span queries with some noise.
  task automatic run_segment(int unsigned npts, int unsigned nq);
    logic [31:0] t;
    send_item(ReqClear, $urandom, rand_point());
    t = $urandom_range(0, 32'hF000_0000);
    for (int unsigned i = 0; i < npts; i++) begin
      send_item(ReqAppend, t, rand_point());
      case ($urandom_range(0, 3))
        0: t += $urandom_range(0, 2);
        1: t += $urandom_range(0, 1000);
        default: t += $urandom_range(0, 200000);
      endcase
    end
    for (int unsigned i = 0; i < nq; i++) begin
      case ($urandom_range(0, 19))
        0: send_item(ReqAppend, $urandom, rand_point());
        1: send_item(2'd3, $urandom, rand_point());
        default: send_item(ReqQuery, span_time(), rand_point());
      endcase
    end
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < out_idle);

  always @(negedge clk) begin
    sample_t e;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d", $realtime, status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.st, status);
          errors++;
        end
        for (int c = 0; c < 9; c++)
          if (mon_ch[c] !== e.ch[c]) begin
            $display("%0t: channel %0d expected %h actual %h",
                     $realtime, c, e.ch[c], mon_ch[c]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if (quiet > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("Some tests failed");
      $finish;
    end
  end

  row_t rows [] = '{
    '{ReqQuery,  32'd5,          '0, 1'b1, StEmpty},
    '{ReqAppend, 32'd100,        {9{32'h8000_0000}}, 1'b1, StOk},
    '{ReqAppend, 32'd100,        {9{32'h7FFF_FFFF}}, 1'b1, StOk},
    '{ReqAppend, 32'd50,         {9{32'h1234_5678}}, 1'b1, StOrder},
    '{ReqAppend, 32'd101,        {9{32'h0001_0000}}, 1'b1, StOk},
    '{ReqAppend, 32'd1101,       {9{32'hFFFF_0000}}, 1'b1, StOk},
    '{ReqAppend, 32'hFFFF_FFF0,  {9{32'h7FFF_FFFF}}, 1'b1, StOk},
    '{ReqQuery,  32'd0,          '0, 1'b0, StOk},
    '{ReqQuery,  32'd100,        '0, 1'b0, StOk},
    '{ReqQuery,  32'd101,        '0, 1'b0, StOk},
    '{ReqQuery,  32'd600,        '0, 1'b0, StOk},
    '{ReqQuery,  32'd1101,       '0, 1'b0, StOk},
    '{ReqQuery,  32'h8000_0000,  '0, 1'b0, StOk},
    '{ReqQuery,  32'hFFFF_FFFF,  '0, 1'b0, StOk},
    '{2'd3,      32'hFFFF_FFFF,  {9{32'hFFFF_FFFF}}, 1'b1, StOk},
    '{ReqClear,  32'd0,          '0, 1'b1, StOk},
    '{ReqQuery,  32'd100,        '0, 1'b1, StEmpty},
    '{ReqAppend, 32'd0,          {9{32'h0000_0001}}, 1'b1, StOk},
    '{ReqQuery,  32'hFFFF_FFFF,  '0, 1'b0, StOk}
  };

  initial begin
    pt_cnt = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i])
      send_item(rows[i].req, rows[i].tm, rows[i].ch, rows[i].typed, rows[i].st);
    repeat (2) run_segment($urandom_range(2, 12), $urandom_range(10, 30));
    // Let the block drain completely before carrying on.
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    @(posedge clk);
    run_segment(TableDepth, 20);
    send_item(ReqAppend, 32'hFFFF_FFFF, rand_point(), 1'b1, StFull);
    while (sent < 1100) run_segment($urandom_range(2, 40), $urandom_range(10, 40));
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/tti_pkg.sv
rtl/tti_front.sv
rtl/tti_div.sv
rtl/tti_back.sv
rtl/trajectory_table_interpolator_top.sv
bench/testbench.sv
